FILE: rtl/lflrp_pkg.sv
// Shared types and codes for the linked free list record pool.
// Used by lflrp_ctrl, lflrp_dp and linked_free_list_record_pool_core.
`default_nettype none
package lflrp_pkg;
	typedef enum logic [2:0] {
		FN_ALLOC = 3'd0, FN_FREE = 3'd1, FN_PUT = 3'd2, FN_GET = 3'd3,
		FN_FCNT = 3'd4, FN_UCNT = 3'd5, FN_ISFREE = 3'd6, FN_NONE = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_NOSPACE = 2'd1, ST_ALREADY = 2'd2, ST_NOTFOUND = 2'd3
	} status_t;

	// commands from controller to datapath
	typedef struct packed {
		logic init_wr;    // write reset contents at init index
		logic ld_in;      // capture input word
		logic walk_set;   // walk pointer <= selected start
		logic walk_src;   // 0: free head, 1: address
		logic rd;         // walk pointer <= read link, step count++
		logic step;       // walk pointer <= read link, step count++
		logic alloc_do;   // perform alloc update
		logic put_wr;     // write data at walk pointer
		logic free_do;    // splice at walk pointer
		logic get_hit;    // latch data from read
		logic out_ld;     // load output register
	} cmd_t;

	typedef struct packed {
		logic walk_null;  // walk pointer is null or step limit reached
		logic link_null;  // read link is null
		logic addr_oor;   // address at or above NODES
		logic hit_addr;   // walk pointer equals address
		logic key_match;  // read key equals input key
		logic head_null;  // free list empty
		logic init_last;  // init sweep on last entry
	} sts_t;
endpackage
`default_nettype wire

FILE: rtl/lflrp_ctrl.sv
// Sequencer for the record pool: init sweep, chain walks, result handshake.
// Depends on lflrp_pkg.
`default_nettype none
module lflrp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire logic [2:0]        func_in,
	input  wire lflrp_pkg::sts_t   sts,
	output lflrp_pkg::cmd_t        cmd,
	output lflrp_pkg::status_t     res_status,
	output logic                   res_isf
);
	typedef enum logic [7:0] {
		S_INIT = 8'b00000001, S_IDLE = 8'b00000010, S_CHKRD = 8'b00000100,
		S_CHK = 8'b00001000, S_WRD = 8'b00010000, S_WALK = 8'b00100000,
		S_DONE = 8'b01000000, S_ARD = 8'b10000000
	} state_t;

	state_t state_q, state_d;
	logic [2:0] func_q;
	logic out_valid_q;
	lflrp_pkg::status_t st_q, st_d;
	logic isf_q, isf_d;

	assign out_valid = out_valid_q;
	assign in_stall = (state_q != S_IDLE) || out_valid_q;
	assign res_status = st_q;
	assign res_isf = isf_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		st_d = st_q;
		isf_d = isf_q;
		case (state_q)
			S_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.init_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid && !out_valid_q) begin
					cmd.ld_in = 1'b1;
					st_d = lflrp_pkg::ST_OK;
					isf_d = 1'b0;
					state_d = S_DONE;
					case (lflrp_pkg::func_t'(func_in))
						lflrp_pkg::FN_ALLOC: state_d = S_ARD;
						lflrp_pkg::FN_FREE, lflrp_pkg::FN_ISFREE: state_d = S_CHKRD;
						lflrp_pkg::FN_PUT, lflrp_pkg::FN_GET: state_d = S_WRD;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_ARD: begin
				cmd.walk_set = 1'b1;
				cmd.walk_src = 1'b0;
				state_d = S_WALK;
				if (sts.head_null) begin
					st_d = lflrp_pkg::ST_NOSPACE;
					state_d = S_DONE;
				end
			end
			S_CHKRD: begin
				if (sts.addr_oor) begin
					if (lflrp_pkg::func_t'(func_q) == lflrp_pkg::FN_FREE)
						st_d = lflrp_pkg::ST_NOTFOUND;
					state_d = S_DONE;
				end else begin
					cmd.walk_set = 1'b1;
					cmd.walk_src = 1'b0;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				// walk free list looking for address
				if (sts.walk_null) begin
					if (lflrp_pkg::func_t'(func_q) == lflrp_pkg::FN_FREE) begin
						cmd.walk_set = 1'b1;
						cmd.walk_src = 1'b1;
						state_d = S_WRD;
					end else state_d = S_DONE;
				end else if (sts.hit_addr) begin
					if (lflrp_pkg::func_t'(func_q) == lflrp_pkg::FN_FREE)
						st_d = lflrp_pkg::ST_ALREADY;
					else isf_d = 1'b1;
					state_d = S_DONE;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_CHK;
				end
			end
			S_WRD: begin
				if (sts.addr_oor) begin
					st_d = lflrp_pkg::ST_NOTFOUND;
					state_d = S_DONE;
				end else begin
					if (lflrp_pkg::func_t'(func_q) != lflrp_pkg::FN_FREE) begin
						cmd.walk_set = 1'b1;
						cmd.walk_src = 1'b1;
					end
					if (lflrp_pkg::func_t'(func_q) == lflrp_pkg::FN_GET)
						st_d = lflrp_pkg::ST_NOTFOUND;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				case (lflrp_pkg::func_t'(func_q))
					lflrp_pkg::FN_ALLOC: begin
						cmd.alloc_do = 1'b1;
						state_d = S_DONE;
					end
					lflrp_pkg::FN_FREE: begin
						if (sts.link_null || sts.walk_null) begin
							cmd.free_do = 1'b1;
							state_d = S_DONE;
						end else cmd.step = 1'b1;
					end
					lflrp_pkg::FN_PUT: begin
						if (sts.walk_null) state_d = S_DONE;
						else begin
							if (sts.key_match) cmd.put_wr = 1'b1;
							cmd.step = 1'b1;
						end
					end
					default: begin
						if (sts.walk_null) state_d = S_DONE;
						else if (sts.key_match) begin
							cmd.get_hit = 1'b1;
							st_d = lflrp_pkg::ST_OK;
							state_d = S_DONE;
						end else cmd.step = 1'b1;
					end
				endcase
			end
			S_DONE: begin
				cmd.out_ld = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			func_q <= '0;
			out_valid_q <= 1'b0;
			st_q <= lflrp_pkg::ST_OK;
			isf_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q <= st_d;
			isf_q <= isf_d;
			if (cmd.ld_in) func_q <= func_in;
			if (cmd.out_ld) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/lflrp_dp.sv
// Datapath for the record pool: node memories, list registers, output word.
// Depends on lflrp_pkg.
`default_nettype none
module lflrp_dp #(
	parameter int NODES    = 256,
	parameter int KEY_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lflrp_pkg::cmd_t     cmd,
	output lflrp_pkg::sts_t          sts,
	input  wire logic [2:0]          func,
	input  wire logic [7:0]          address,
	input  wire logic [15:0]         key,
	input  wire logic signed [31:0]  value,
	input  wire logic                last,
	input  wire lflrp_pkg::status_t  res_status,
	input  wire logic                res_isf,
	output logic [1:0]               status,
	output logic [7:0]               start_address,
	output logic signed [31:0]       data,
	output logic [8:0]               count,
	output logic                     is_free
);
	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int LW = $clog2(NODES + 1);
	localparam int KW = (KEY_BITS < 16) ? KEY_BITS : 16;
	localparam logic [LW-1:0] NULLP = LW'(NODES);

	// link memory holds the reset chain; key/data start at zero via sweep
	logic [LW-1:0] link_mem [NODES];
	logic [KW-1:0] key_mem  [NODES];
	logic [31:0]   data_mem [NODES];

	logic [LW-1:0] walk_q, free_head_q, chain_start_q, chain_tail_q;
	logic [LW:0]   free_total_q;
	logic [LW:0]   steps_q, len_q;
	logic [AW-1:0] init_q;
	logic [2:0]    func_q;
	logic [7:0]    addr_q;
	logic [KW-1:0] key_q;
	logic [31:0]   value_q;
	logic          last_q;
	logic [31:0]   hit_q;
	logic [LW-1:0] walk_d;
	logic [LW-1:0] link_rd_q;
	logic [KW-1:0] key_rd_q;
	logic [LW-1:0] cur_link;
	logic [KW-1:0] cur_key;
	logic [LW-1:0] addr_ext;
	logic [LW:0]   sum;
	logic          in_range;

	assign addr_ext = LW'(addr_q);
	assign in_range = ({1'b0, addr_q} < 9'(NODES)) || (LW > 8);
	// link and key reads are registered, addressed by the next walk pointer
	assign cur_link = (walk_q < NULLP) ? link_rd_q : NULLP;
	assign cur_key  = (walk_q < NULLP) ? key_rd_q : '0;
	assign sum = free_total_q + len_q;

	always_comb begin
		walk_d = walk_q;
		if (cmd.walk_set) walk_d = cmd.walk_src ? addr_ext : free_head_q;
		else if (cmd.rd || cmd.step) walk_d = cur_link;
	end

	always_comb begin
		sts.walk_null = (walk_q >= NULLP) || (steps_q >= (LW+1)'(NODES));
		sts.link_null = cur_link >= NULLP;
		sts.addr_oor  = (LW <= 8) ? !in_range : 1'b0;
		sts.hit_addr  = walk_q == addr_ext;
		sts.key_match = cur_key == key_q;
		sts.head_null = free_head_q >= NULLP;
		sts.init_last = init_q == AW'(NODES - 1);
	end

	always_ff @(posedge clk) begin
		link_rd_q <= link_mem[walk_d[AW-1:0]];
		key_rd_q <= key_mem[walk_d[AW-1:0]];
		if (cmd.init_wr) begin
			link_mem[init_q] <= LW'(init_q) + LW'(1);
			key_mem[init_q] <= '0;
			data_mem[init_q] <= '0;
		end
		if (cmd.ld_in) begin
			func_q <= func;
			addr_q <= address;
			key_q <= key[KW-1:0];
			value_q <= value;
			last_q <= last;
		end
		if (cmd.put_wr) data_mem[walk_q[AW-1:0]] <= value_q;
		if (cmd.get_hit) hit_q <= data_mem[walk_q[AW-1:0]];
		if (cmd.alloc_do) begin
			link_mem[walk_q[AW-1:0]] <= NULLP;
			key_mem[walk_q[AW-1:0]] <= key_q;
			if (chain_tail_q < NULLP) link_mem[chain_tail_q[AW-1:0]] <= walk_q;
		end
		if (cmd.free_do) link_mem[walk_q[AW-1:0]] <= free_head_q;
		if (cmd.out_ld) begin
			status <= res_status;
			is_free <= res_isf;
			start_address <= '0;
			data <= '0;
			count <= '0;
			case (lflrp_pkg::func_t'(func_q))
				lflrp_pkg::FN_ALLOC:
					if (res_status == lflrp_pkg::ST_OK && last_q)
						start_address <= 8'(chain_start_q);
				lflrp_pkg::FN_GET:
					if (res_status == lflrp_pkg::ST_OK) data <= hit_q;
				lflrp_pkg::FN_FCNT: count <= 9'(free_total_q);
				lflrp_pkg::FN_UCNT: count <= 9'((LW+1)'(NODES) - free_total_q);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
			free_head_q <= '0;
			chain_start_q <= '0;
			chain_tail_q <= NULLP;
			free_total_q <= (LW+1)'(NODES);
			steps_q <= '0;
			len_q <= '0;
			init_q <= '0;
		end else begin
			if (cmd.init_wr) init_q <= init_q + AW'(1);
			walk_q <= walk_d;
			if (cmd.walk_set) begin
				steps_q <= '0;
				len_q <= (LW+1)'(1);
			end else if (cmd.rd || cmd.step) begin
				steps_q <= steps_q + (LW+1)'(1);
				len_q <= len_q + (LW+1)'(1);
			end
			if (cmd.alloc_do) begin
				free_head_q <= cur_link;
				if (free_total_q != '0) free_total_q <= free_total_q - (LW+1)'(1);
				if (chain_tail_q >= NULLP) chain_start_q <= walk_q;
				chain_tail_q <= last_q ? NULLP : walk_q;
			end
			if (cmd.free_do) begin
				free_head_q <= addr_ext;
				free_total_q <= (sum > (LW+1)'(NODES)) ? (LW+1)'(NODES) : sum;
				if (chain_tail_q < NULLP && addr_ext == chain_start_q)
					chain_tail_q <= NULLP;
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/linked_free_list_record_pool_core.sv
// Top level of the linked free list record pool.
// Depends on lflrp_pkg, lflrp_ctrl and lflrp_dp.
`default_nettype none
// One word in, one word out per item; one item at a time. After reset the
// block sweeps the node memories before taking a word. Counts and the
// unused selector answer at once; alloc takes the head of the free list or
// reports no space; put and get walk the chain from the address and is-free
// walks the free list, the final null check included; free walks the free
// list and then the chain. The walks step through the single registered
// read port of the link and key memories.
module linked_free_list_record_pool_core #(
	parameter int NODES    = 256,
	parameter int KEY_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         func,
	input  wire logic [7:0]         address,
	input  wire logic [15:0]        key,
	input  wire logic signed [31:0] value,
	input  wire logic               last,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic [7:0]              start_address,
	output logic signed [31:0]      data,
	output logic [8:0]              count,
	output logic                    is_free
);
	lflrp_pkg::cmd_t    cmd;
	lflrp_pkg::sts_t    sts;
	lflrp_pkg::status_t res_status;
	logic               res_isf;

	lflrp_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.func_in(func), .sts, .cmd, .res_status, .res_isf
	);

	lflrp_dp #(.NODES(NODES), .KEY_BITS(KEY_BITS)) u_dp (
		.clk, .arst_n, .cmd, .sts, .func, .address, .key, .value, .last,
		.res_status, .res_isf, .status, .start_address, .data, .count, .is_free
	);
endmodule
`default_nettype wire
